@@ src/w2hb_pkg.sv @@
// ----------------------------------------------------------------------------
// w2hb_pkg: shared types and constants of the weighted 2-D histogram binner
// Field widths, fixed-point constants, register indexes, opcodes and states.
// ----------------------------------------------------------------------------
package w2hb_pkg;

  localparam int DIST_W      = 32;
  localparam int ANGLE_W     = 18;
  localparam int WEIGHT_W    = 32;
  localparam int IDX_W       = 15;
  localparam int BIN_W       = 48;
  localparam int INV_W       = 24;
  localparam int BINS_R_W    = 9;
  localparam int BINS_TH_W   = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;

  // Products and the integer bin parts taken from them
  localparam int PROD_R_W    = DIST_W - 1 + INV_W;   // positive distance only
  localparam int PROD_TH_W   = ANGLE_W + INV_W;
  localparam int FRAC_SHIFT  = 32;
  localparam int BR_RAW_W    = PROD_R_W - FRAC_SHIFT;
  localparam int BTH_RAW_W   = PROD_TH_W - FRAC_SHIFT;

  localparam logic [ANGLE_W-1:0] PI_Q2_16 = 18'd205887;
  localparam logic [BIN_W-1:0]   BIN_MAX  = {BIN_W{1'b1}};

  localparam logic [INV_W-1:0]     INV_R_RST   = 24'd6553600;
  localparam logic [INV_W-1:0]     INV_TH_RST  = 24'd1877411;
  localparam logic [BINS_R_W-1:0]  BINS_R_RST  = 9'd256;
  localparam logic [BINS_TH_W-1:0] BINS_TH_RST = 8'd90;

  localparam int MAX_BINS_R_DEF  = 256;
  localparam int MAX_BINS_TH_DEF = 128;

  localparam logic [CFG_IDX_W-1:0] CFG_INV_R   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_TH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_R  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_TH = 2'd3;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_RD,
    S_WR,
    S_OUT
  } state_e;

endpackage

@@ src/weighted_2d_histogram_binner.sv @@
// Sequence from request accept to result valid: multiply, address and memory read,
// read-modify-write, output load. One request at a time: a new request is taken
// only after the last one's result is loaded into the output register.
// The single-port-write, registered-read bin memory paces the sequence.
// Reset: after rst_ni rises the block zeroes all MAX_BINS_R*MAX_BINS_TH bins,
// one per cycle, before it takes a request; config writes are taken meanwhile.
// ----------------------------------------------------------------------------
// weighted_2d_histogram_binner
// Weighted 2-D histogram over distance and angle with saturating bins in a
// synchronous memory; add, read and clear requests, one result each.
// ----------------------------------------------------------------------------
module weighted_2d_histogram_binner #(
  parameter int MAX_BINS_R  = w2hb_pkg::MAX_BINS_R_DEF,
  parameter int MAX_BINS_TH = w2hb_pkg::MAX_BINS_TH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [w2hb_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [w2hb_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           opcode_i,
  input  logic signed [w2hb_pkg::DIST_W-1:0]   distance_i,
  input  logic [w2hb_pkg::ANGLE_W-1:0]         angle_i,
  input  logic [w2hb_pkg::WEIGHT_W-1:0]        weight_i,
  input  logic [w2hb_pkg::IDX_W-1:0]           bin_index_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 accepted_o,
  output logic [w2hb_pkg::BIN_W-1:0]           read_value_o
);

  localparam int DEPTH  = MAX_BINS_R * MAX_BINS_TH;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = ((AW > w2hb_pkg::IDX_W) ? AW : w2hb_pkg::IDX_W) + 1;
  localparam int RIW    = $clog2(MAX_BINS_R);
  localparam int TIW    = $clog2(MAX_BINS_TH);
  localparam int NRW    = ($clog2(MAX_BINS_R + 1) > w2hb_pkg::BINS_R_W) ?
                          $clog2(MAX_BINS_R + 1) : w2hb_pkg::BINS_R_W;
  localparam int NTW    = ($clog2(MAX_BINS_TH + 1) > w2hb_pkg::BINS_TH_W) ?
                          $clog2(MAX_BINS_TH + 1) : w2hb_pkg::BINS_TH_W;
  localparam int CMPR_W = ((NRW > w2hb_pkg::BR_RAW_W) ? NRW : w2hb_pkg::BR_RAW_W) + 1;
  localparam int CMPT_W = ((NTW > w2hb_pkg::BTH_RAW_W) ? NTW : w2hb_pkg::BTH_RAW_W) + 1;

  // Configuration registers
  logic [w2hb_pkg::INV_W-1:0]     inv_r_q, inv_th_q;
  logic [w2hb_pkg::BINS_R_W-1:0]  bins_r_q;
  logic [w2hb_pkg::BINS_TH_W-1:0] bins_th_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_r_q   <= w2hb_pkg::INV_R_RST;
      inv_th_q  <= w2hb_pkg::INV_TH_RST;
      bins_r_q  <= w2hb_pkg::BINS_R_RST;
      bins_th_q <= w2hb_pkg::BINS_TH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        w2hb_pkg::CFG_INV_R:   inv_r_q   <= cfg_data_i[w2hb_pkg::INV_W-1:0];
        w2hb_pkg::CFG_INV_TH:  inv_th_q  <= cfg_data_i[w2hb_pkg::INV_W-1:0];
        w2hb_pkg::CFG_BINS_R:  bins_r_q  <= cfg_data_i[w2hb_pkg::BINS_R_W-1:0];
        w2hb_pkg::CFG_BINS_TH: bins_th_q <= cfg_data_i[w2hb_pkg::BINS_TH_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state
  w2hb_pkg::state_e state_q, state_d;
  logic [AW-1:0]    clr_q;
  logic             out_valid_q;
  logic             out_load;

  // Request and datapath registers
  logic [1:0]                            op_q;
  logic [w2hb_pkg::DIST_W-1:0]           dist_q;
  logic [w2hb_pkg::ANGLE_W-1:0]          angle_q;
  logic [w2hb_pkg::WEIGHT_W-1:0]         weight_q;
  logic [w2hb_pkg::IDX_W-1:0]            idx_q;
  logic [w2hb_pkg::PROD_R_W-1:0]         prod_r_q;
  logic [w2hb_pkg::PROD_TH_W-1:0]        prod_th_q;
  logic [AW-1:0]                         addr_q;
  logic                                  add_ok_q, idx_ok_q;
  logic [w2hb_pkg::BIN_W-1:0]            rdata_q;
  logic                                  res_acc_q;
  logic [w2hb_pkg::BIN_W-1:0]            res_val_q;
  logic                                  accepted_q;
  logic [w2hb_pkg::BIN_W-1:0]            read_value_q;

  // Memory port signals
  logic                        mem_we, mem_re;
  logic [AW-1:0]               mem_wa, mem_ra;
  logic [w2hb_pkg::BIN_W-1:0]  mem_wd;
  logic [w2hb_pkg::BIN_W-1:0]  mem [DEPTH];

  // Bin index arithmetic (S_RD) and saturating bin sum (S_WR)
  logic [w2hb_pkg::BR_RAW_W-1:0]  br_raw;
  logic [w2hb_pkg::BTH_RAW_W-1:0] bth_raw;
  logic [NRW-1:0]                 nr;
  logic [NTW-1:0]                 nth;
  logic [RIW-1:0]                 br_c;
  logic [TIW-1:0]                 bth_c;
  logic                           dist_ok, angle_ok, br_ok;
  logic [AW-1:0]                  add_addr;
  logic                           add_ok, idx_ok;
  logic [w2hb_pkg::BIN_W:0]       sum;
  logic [w2hb_pkg::BIN_W-1:0]     sum_sat;

  always_comb begin
    br_raw  = prod_r_q[w2hb_pkg::PROD_R_W-1:w2hb_pkg::FRAC_SHIFT];
    bth_raw = prod_th_q[w2hb_pkg::PROD_TH_W-1:w2hb_pkg::FRAC_SHIFT];
    nr  = (NRW'(bins_r_q) > NRW'(MAX_BINS_R)) ? NRW'(MAX_BINS_R) : NRW'(bins_r_q);
    nth = (NTW'(bins_th_q) > NTW'(MAX_BINS_TH)) ? NTW'(MAX_BINS_TH) : NTW'(bins_th_q);
    dist_ok  = !dist_q[w2hb_pkg::DIST_W-1] && (dist_q != '0);
    angle_ok = angle_q <= w2hb_pkg::PI_Q2_16;
    br_ok    = CMPR_W'(br_raw) < CMPR_W'(nr);
    br_c     = RIW'(br_raw);
    // clamp an angle bin past the end (angle of exactly pi) into the last bin
    if (CMPT_W'(bth_raw) >= CMPT_W'(nth)) begin
      bth_c = TIW'(nth - NTW'(1));
    end else begin
      bth_c = TIW'(bth_raw);
    end
    add_ok   = dist_ok && angle_ok && (nth != '0) && br_ok;
    add_addr = AW'(bth_c) * AW'(MAX_BINS_R) + AW'(br_c);
    idx_ok   = CW'(idx_q) < CW'(DEPTH);
    sum      = {1'b0, rdata_q} + (w2hb_pkg::BIN_W + 1)'(weight_q);
    sum_sat  = sum[w2hb_pkg::BIN_W] ? w2hb_pkg::BIN_MAX : sum[w2hb_pkg::BIN_W-1:0];
  end

  // Next state and control outputs
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = addr_q;
    mem_wd     = '0;
    mem_re     = 1'b0;
    mem_ra     = add_addr;
    out_load   = 1'b0;
    unique case (state_q)
      w2hb_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = w2hb_pkg::S_IDLE;
        end
      end
      w2hb_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = w2hb_pkg::S_MUL;
        end
      end
      w2hb_pkg::S_MUL: begin
        state_d = w2hb_pkg::S_RD;
      end
      w2hb_pkg::S_RD: begin
        mem_re = 1'b1;
        if (op_q != w2hb_pkg::OP_ADD) begin
          mem_ra = AW'(idx_q);
        end
        state_d = w2hb_pkg::S_WR;
      end
      w2hb_pkg::S_WR: begin
        unique case (op_q)
          w2hb_pkg::OP_ADD: begin
            mem_we = add_ok_q;
            mem_wd = sum_sat;
          end
          w2hb_pkg::OP_CLEAR: begin
            mem_we = idx_ok_q;
          end
          default: ;
        endcase
        state_d = w2hb_pkg::S_OUT;
      end
      w2hb_pkg::S_OUT: begin
        // hold the result until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = w2hb_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = w2hb_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= w2hb_pkg::S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == w2hb_pkg::S_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Bin memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_ra];
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q     <= opcode_i;
      dist_q   <= distance_i;
      angle_q  <= angle_i;
      weight_q <= weight_i;
      idx_q    <= bin_index_i;
    end
    if (state_q == w2hb_pkg::S_MUL) begin
      prod_r_q  <= (w2hb_pkg::PROD_R_W)'(dist_q[w2hb_pkg::DIST_W-2:0]) *
                   (w2hb_pkg::PROD_R_W)'(inv_r_q);
      prod_th_q <= (w2hb_pkg::PROD_TH_W)'(angle_q) * (w2hb_pkg::PROD_TH_W)'(inv_th_q);
    end
    if (state_q == w2hb_pkg::S_RD) begin
      addr_q   <= (op_q == w2hb_pkg::OP_ADD) ? add_addr : AW'(idx_q);
      add_ok_q <= add_ok;
      idx_ok_q <= idx_ok;
    end
    if (state_q == w2hb_pkg::S_WR) begin
      res_acc_q <= (op_q == w2hb_pkg::OP_ADD) && add_ok_q;
      res_val_q <= ((op_q == w2hb_pkg::OP_READ) && idx_ok_q) ? rdata_q : '0;
    end
    if (out_load) begin
      accepted_q   <= res_acc_q;
      read_value_q <= res_val_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign accepted_o   = accepted_q;
  assign read_value_o = read_value_q;

  // Assertions
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (CW'(mem_wa) < CW'(DEPTH)))
    else $error("bin write outside the store");

  a_wr_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && (state_q != w2hb_pkg::S_CLEAR)) |-> (state_q == w2hb_pkg::S_WR))
    else $error("bin write outside the write phase");

  a_acc_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && accepted_o) |-> (read_value_o == '0))
    else $error("accepted add carries a read value");

endmodule

@@ tb/tb_weighted_2d_histogram_binner.sv @@
// ----------------------------------------------------------------------------
// tb_weighted_2d_histogram_binner: self-checking bench for the 2-D histogram
// Drives add, read, clear and unused-opcode requests under random sender gaps
// and receiver stalls, mirrors the bin store and registers in a local predictor, and
// checks every result in order. Covers rejection rules, angle clamping,
// oversized and zero bin counts, extreme bin widths and full-scale weights.
// ----------------------------------------------------------------------------
module tb_weighted_2d_histogram_binner;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = w2hb_pkg::MAX_BINS_R_DEF * w2hb_pkg::MAX_BINS_TH_DEF;
  localparam int SETTLE_CYCLES  = 10;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int HOT_KEEP       = 48;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic                       hit;
    logic [w2hb_pkg::BIN_W-1:0] value;
  } bin_result_t;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 cfg_we_i = 1'b0;
  logic [w2hb_pkg::CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [w2hb_pkg::CFG_DATA_W-1:0]      cfg_data_i = '0;
  logic                                 in_valid_i = 1'b0;
  logic                                 in_ready_o;
  logic [1:0]                           opcode_i = '0;
  logic signed [w2hb_pkg::DIST_W-1:0]   distance_i = '0;
  logic [w2hb_pkg::ANGLE_W-1:0]         angle_i = '0;
  logic [w2hb_pkg::WEIGHT_W-1:0]        weight_i = '0;
  logic [w2hb_pkg::IDX_W-1:0]           bin_index_i = '0;
  logic                                 out_valid_o;
  logic                                 out_ready_i = 1'b0;
  logic                                 accepted_o;
  logic [w2hb_pkg::BIN_W-1:0]           read_value_o;

  weighted_2d_histogram_binner dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .distance_i   (distance_i),
    .angle_i      (angle_i),
    .weight_i     (weight_i),
    .bin_index_i  (bin_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .accepted_o   (accepted_o),
    .read_value_o (read_value_o)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state
  logic [w2hb_pkg::BIN_W-1:0]     bin_mirror [DEPTH];
  logic [w2hb_pkg::INV_W-1:0]     scale_r  = w2hb_pkg::INV_R_RST;
  logic [w2hb_pkg::INV_W-1:0]     scale_th = w2hb_pkg::INV_TH_RST;
  logic [w2hb_pkg::BINS_R_W-1:0]  nbins_r  = w2hb_pkg::BINS_R_RST;
  logic [w2hb_pkg::BINS_TH_W-1:0] nbins_th = w2hb_pkg::BINS_TH_RST;
  bin_result_t                    expected_q [$];
  int                             hot_bins [$];

  int  mismatch_cnt = 0;
  int  stall_cycles = 0;
  int  cycle_cnt = 0;
  bit  pace_on = 1'b1;
  bit  sink_stalls = 1'b1;
  bit  req_up = 1'b0;
  int  burst_left = 0;
  int  sink_mode = 0;
  int  sink_left = 0;

  // Apply one request to the mirror and return what the block should answer
  function automatic bin_result_t histogram_apply(logic [1:0] op, logic [31:0] dist_v,
                                                  logic [17:0] ang, logic [31:0] wt,
                                                  logic [14:0] idx);
    bin_result_t res;
    int unsigned nr, nth, addr;
    logic [63:0] br, bth;
    logic [48:0] sum;
    res = '0;
    nr  = (nbins_r > w2hb_pkg::MAX_BINS_R_DEF) ? w2hb_pkg::MAX_BINS_R_DEF : nbins_r;
    nth = (nbins_th > w2hb_pkg::MAX_BINS_TH_DEF) ? w2hb_pkg::MAX_BINS_TH_DEF : nbins_th;
    if (op == w2hb_pkg::OP_ADD) begin
      br  = (64'(dist_v) * 64'(scale_r)) >> 32;
      bth = (64'(ang) * 64'(scale_th)) >> 32;
      if (!dist_v[31] && dist_v != 0 && ang <= w2hb_pkg::PI_Q2_16 && nr != 0 &&
          nth != 0 && br < 64'(nr)) begin
        if (bth >= 64'(nth)) bth = 64'(nth - 1);
        addr = int'(bth) * w2hb_pkg::MAX_BINS_R_DEF + int'(br);
        if (addr < DEPTH) begin
          sum = {1'b0, bin_mirror[addr]} + 49'(wt);
          bin_mirror[addr] = sum[48] ? w2hb_pkg::BIN_MAX : sum[w2hb_pkg::BIN_W-1:0];
          res.hit = 1'b1;
          hot_bins.push_back(addr);
          if (hot_bins.size() > HOT_KEEP) void'(hot_bins.pop_front());
        end
      end
    end else if (op == w2hb_pkg::OP_READ) begin
      if (int'(idx) < DEPTH) res.value = bin_mirror[idx];
    end else if (op == w2hb_pkg::OP_CLEAR) begin
      if (int'(idx) < DEPTH) bin_mirror[idx] = '0;
    end
    return res;
  endfunction

  // Largest distance that still lands inside the distance bins in use
  function automatic logic [31:0] dist_limit();
    logic [63:0] span;
    int unsigned nr;
    nr = (nbins_r > w2hb_pkg::MAX_BINS_R_DEF) ? w2hb_pkg::MAX_BINS_R_DEF : nbins_r;
    if (nr == 0) nr = 1;
    span = ((64'(nr) << 32) - 1) / 64'(scale_r);
    if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
    if (span == 0) span = 1;
    return span[31:0];
  endfunction

  function automatic logic [14:0] pick_index(int hot_pct);
    if (hot_bins.size() != 0 && $urandom_range(0, 99) < hot_pct)
      return 15'(hot_bins[$urandom_range(0, hot_bins.size() - 1)]);
    return 15'($urandom);
  endfunction

  task automatic write_reg(logic [w2hb_pkg::CFG_IDX_W-1:0] idx,
                           logic [w2hb_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      w2hb_pkg::CFG_INV_R:   scale_r  = data[w2hb_pkg::INV_W-1:0];
      w2hb_pkg::CFG_INV_TH:  scale_th = data[w2hb_pkg::INV_W-1:0];
      w2hb_pkg::CFG_BINS_R:  nbins_r  = data[w2hb_pkg::BINS_R_W-1:0];
      w2hb_pkg::CFG_BINS_TH: nbins_th = data[w2hb_pkg::BINS_TH_W-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [23:0] inv_r, logic [23:0] inv_th,
                            logic [23:0] cnt_r, logic [23:0] cnt_th);
    write_reg(w2hb_pkg::CFG_INV_R, inv_r);
    write_reg(w2hb_pkg::CFG_INV_TH, inv_th);
    write_reg(w2hb_pkg::CFG_BINS_R, cnt_r);
    write_reg(w2hb_pkg::CFG_BINS_TH, cnt_th);
  endtask

  task automatic send_req(logic [1:0] op, logic [31:0] dist_v, logic [17:0] ang,
                          logic [31:0] wt, logic [14:0] idx);
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    distance_i  <= dist_v;
    angle_i     <= ang;
    weight_i    <= wt;
    bin_index_i <= idx;
    req_up = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_q.push_back(histogram_apply(op, dist_v, ang, wt, idx));
    // keep valid up inside a burst, drop it for a gap between bursts
    if (!pace_on || burst_left > 0) begin
      if (burst_left > 0) burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      req_up = 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic wait_idle();
    if (req_up) begin
      in_valid_i <= 1'b0;
      req_up = 1'b0;
    end
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_directed_edges();
    logic [31:0] lim;
    lim = dist_limit();
    send_req(w2hb_pkg::OP_ADD, 32'h0000_0001, 18'd0, 32'hFFFF_FFFF, 15'd0);
    send_req(w2hb_pkg::OP_READ, 32'd0, 18'd0, 32'd0, 15'd0);
    send_req(w2hb_pkg::OP_ADD, 32'h0000_0000, 18'd100, 32'd7, 15'd0);
    send_req(w2hb_pkg::OP_ADD, 32'hFFFF_FFFF, 18'd100, 32'd7, 15'd0);
    send_req(w2hb_pkg::OP_ADD, 32'h8000_0000, 18'd100, 32'd7, 15'd0);
    send_req(w2hb_pkg::OP_ADD, 32'h7FFF_FFFF, 18'd100, 32'd7, 15'd0);
    // last distance bin, angle exactly pi lands in the last angle bin
    send_req(w2hb_pkg::OP_ADD, lim, w2hb_pkg::PI_Q2_16, 32'h0001_0000, 15'd0);
    send_req(w2hb_pkg::OP_READ, 32'd0, 18'd0, 32'd0, 15'(hot_bins[$]));
    send_req(w2hb_pkg::OP_ADD, lim + 32'd1, 18'd0, 32'd9, 15'd0);
    send_req(w2hb_pkg::OP_ADD, 32'h0000_1000, w2hb_pkg::PI_Q2_16 + 18'd1, 32'd9, 15'd0);
    send_req(w2hb_pkg::OP_ADD, 32'h0000_1000, 18'h3FFFF, 32'd9, 15'd0);
    send_req(w2hb_pkg::OP_ADD, 32'h0000_0001, 18'd0, 32'd0, 15'd0);
    send_req(w2hb_pkg::OP_READ, 32'd0, 18'd0, 32'd0, 15'h7FFF);
    send_req(w2hb_pkg::OP_CLEAR, 32'd0, 18'd0, 32'd0, 15'd0);
    send_req(w2hb_pkg::OP_READ, 32'd0, 18'd0, 32'd0, 15'd0);
    send_req(OP_UNUSED, 32'hFFFF_FFFF, 18'h3FFFF, 32'hFFFF_FFFF, 15'h7FFF);
    send_req(w2hb_pkg::OP_ADD, 32'h0000_0002, w2hb_pkg::PI_Q2_16, 32'd5, 15'd0);
    send_req(w2hb_pkg::OP_ADD, 32'h0000_0002, w2hb_pkg::PI_Q2_16, 32'hFFFF_0000, 15'd0);
    send_req(w2hb_pkg::OP_READ, 32'hFFFF_FFFF, 18'h3FFFF, 32'hFFFF_FFFF,
             15'(hot_bins[$]));
    send_req(w2hb_pkg::OP_CLEAR, 32'd0, 18'd0, 32'd0, 15'h5A5A);
    send_req(w2hb_pkg::OP_READ, 32'd0, 18'd0, 32'd0, 15'h5A5A);
    wait_idle();
  endtask

  // Adds aimed at the bins in use for half the requests, mixed with reads, clears and noise
  task automatic test_traffic(int n);
    int          pick;
    logic [31:0] lim, d, w;
    logic [17:0] a;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      lim  = dist_limit();
      case ($urandom_range(0, 3))
        0:       w = 32'($urandom_range(0, 255)) << 16;
        3:       w = 32'hFFFF_FFFF;
        default: w = $urandom;
      endcase
      if (pick < 50) begin
        case ($urandom_range(0, 9))
          0:       d = lim;
          1:       d = lim + 1;
          default: d = $urandom_range(1, lim);
        endcase
        case ($urandom_range(0, 19))
          0, 1:    a = w2hb_pkg::PI_Q2_16;
          2:       a = 18'd0;
          default: a = 18'($urandom_range(0, w2hb_pkg::PI_Q2_16));
        endcase
        send_req(w2hb_pkg::OP_ADD, d, a, w, 15'($urandom));
      end else if (pick < 70) begin
        send_req(w2hb_pkg::OP_READ, $urandom, 18'($urandom), $urandom, pick_index(80));
      end else if (pick < 78) begin
        send_req(w2hb_pkg::OP_CLEAR, $urandom, 18'($urandom), $urandom, pick_index(70));
      end else if (pick < 82) begin
        send_req(OP_UNUSED, $urandom, 18'($urandom), $urandom, 15'($urandom));
      end else begin
        case ($urandom_range(0, 2))
          0:       d = -$urandom_range(0, 1000);
          default: d = $urandom;
        endcase
        send_req(w2hb_pkg::OP_ADD, d, 18'($urandom), w, 15'($urandom));
      end
    end
    wait_idle();
  endtask

  task automatic test_narrow_bins();
    set_config(24'd1, 24'd1, 24'd1, 24'd1);
    test_traffic(100);
  endtask

  task automatic test_fine_bins();
    set_config(24'hFF_FFFF, 24'hFF_FFFF, 24'd256, 24'd128);
    test_traffic(120);
  endtask

  task automatic test_oversized_counts();
    // upper data bits beyond the register width are dropped
    set_config(24'($urandom_range(65536, 8388608)), 24'($urandom_range(65536, 4194304)),
               {15'($urandom), 9'd511}, {16'($urandom), 8'd255});
    test_traffic(60);
    set_config(24'($urandom_range(1000000, 16777215)), 24'd1877411, 24'd300, 24'd129);
    test_traffic(60);
  endtask

  task automatic test_zero_counts();
    set_config(24'd6553600, 24'd1877411, 24'd0, 24'd90);
    test_traffic(40);
    set_config(24'd6553600, 24'd1877411, 24'd256, 24'd0);
    test_traffic(40);
  endtask

  task automatic test_mid_config();
    repeat (2) begin
      set_config(24'($urandom_range(1, 16777215)), 24'($urandom_range(1, 16777215)),
                 24'($urandom_range(1, 256)), 24'($urandom_range(1, 128)));
      test_traffic(70);
    end
  endtask

  // Full-scale adds pile up in one bin, read back along the way; run without idling
  task automatic test_full_scale_adds();
    int k;
    pace_on = 1'b0;
    sink_stalls = 1'b0;
    set_config(24'd65536, 24'd65536, 24'd256, 24'd128);
    send_req(w2hb_pkg::OP_CLEAR, 32'd0, 18'd0, 32'd0, 15'd0);
    for (k = 0; k < 60; k++) begin
      send_req(w2hb_pkg::OP_ADD, 32'h0000_8000, 18'd0, 32'hFFFF_FFFF, 15'd0);
      if (k % 8 == 7)
        send_req(w2hb_pkg::OP_READ, 32'd0, 18'd0, 32'd0, 15'd0);
    end
    wait_idle();
    pace_on = 1'b1;
    sink_stalls = 1'b1;
  endtask

  // Receiver: stall pattern switches between always ready, coin flip,
  // one-in-four and long stalls
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!sink_stalls) begin
      out_ready_i <= 1'b1;
    end else begin
      if (sink_left == 0) begin
        sink_mode <= $urandom_range(0, 3);
        sink_left <= $urandom_range(16, 96);
      end else begin
        sink_left <= sink_left - 1;
      end
      case (sink_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        2:       out_ready_i <= (cycle_cnt[1:0] == 2'd0);
        default: out_ready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    bin_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: accepted=%0b read_value=%h", accepted_o,
                   read_value_o);
      end else begin
        want = expected_q.pop_front();
        if (accepted_o !== want.hit) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("accepted mismatch: expected %0b got %0b", want.hit, accepted_o);
        end
        if (read_value_o !== want.value) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("read_value mismatch: expected %h got %h", want.value,
                     read_value_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int i;
    for (i = 0; i < DEPTH; i++) bin_mirror[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_traffic(300);
    test_narrow_bins();
    test_fine_bins();
    test_oversized_counts();
    test_zero_counts();
    test_mid_config();
    test_full_scale_adds();
    wait_idle();
    if (mismatch_cnt == 0 && expected_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
